@@ rtl/core/ptts_pkg.sv @@
// Shared types and constants for the periodic task table scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ptts_pkg;
  localparam int MAX_TASKS_DEF = 16;
  localparam int CNT_W = 15;
  localparam int ID_W = 8;
  localparam int IN_W = 27;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 24;
  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_QUICK = 3'd2;
  localparam logic [2:0] MODE_RESTART = 3'd3;
  localparam logic [2:0] MODE_STOP = 3'd4;

  // divider request / response
  typedef struct packed {
    logic start;
    logic [CNT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [CNT_W-1:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ rtl/core/ptts_div.sv @@
// Restoring divider, one quotient bit per cycle, 15-bit unsigned.
`timescale 1ns / 1ps
`default_nettype none
module ptts_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire ptts_pkg::div_req_t req,
  output ptts_pkg::div_rsp_t rsp
);
  import ptts_pkg::*;

  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] quo;
  logic [CNT_W-1:0] dvs;
  logic [3:0] cnt;
  logic busy;
  logic done;
  logic [CNT_W:0] trial;

  assign trial = {rem, quo[CNT_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
        cnt <= 4'(CNT_W - 1);
      end else if (busy) begin
        if (trial[CNT_W]) begin
          rem <= {rem[CNT_W-2:0], quo[CNT_W-1]};
          quo <= {quo[CNT_W-2:0], 1'b0};
        end else begin
          rem <= trial[CNT_W-1:0];
          quo <= {quo[CNT_W-2:0], 1'b1};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 4'd1;
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.quotient = quo;
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("divider done without work");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy && cnt != '0 |=> busy) else $error("divider stopped early");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy) else $error("divider did not start");
endmodule
`default_nettype wire

@@ rtl/core/periodic_task_table_scheduler_core.sv @@
// Top level: task table, sequencer and output register.
// A command passes through search, decide and, for a removal, the shift walk before completion;
// a tick walks the table entry by entry, skipping zero-period entries, and runs the
// shared 15-bit divider twice per other entry (old and new counter).
// One item at a time; s_tready is low from accept until the completion transaction is loaded
// into the output register; output stalls add cycles. Reset empties table, zeroes counter.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_table_scheduler_core #(
  parameter int MAX_TASKS = ptts_pkg::MAX_TASKS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  // tdata: mode[2:0], task_id[10:3], period_ms[26:11], zero fill
  input  wire logic [ptts_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic m_tvalid,
  input  wire logic m_tready,
  // tdata: fired_id[7:0], fired_period[22:8], zero fill
  output logic [ptts_pkg::OUT_TDATA_W-1:0] m_tdata,
  // tuser: kind[0], error[1], became_busy[2], became_idle[3]
  output logic [3:0] m_tuser,
  output logic m_tlast
);
  import ptts_pkg::*;
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_DECIDE, S_SHIFT, S_TRD, S_DIV0, S_DIV1, S_EMIT, S_DONE
  } state_t;

  state_t state;
  logic [ID_W-1:0] ids [MAX_TASKS];
  logic [CNT_W-1:0] pers [MAX_TASKS];
  logic [CW-1:0] count;
  logic [CNT_W-1:0] ms_counter;
  logic [CNT_W-1:0] next_cnt;
  logic [2:0] mode;
  logic [ID_W-1:0] tid;
  logic [15:0] per_in;
  logic [CW-1:0] idx;
  logic [ID_W-1:0] rd_id;
  logic [CNT_W-1:0] rd_per;
  logic [CNT_W-1:0] q0;
  logic err, busy_f, idle_f;
  logic found;
  div_req_t dreq;
  div_rsp_t drsp;

  ptts_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign s_tready = (state == S_IDLE);
  assign found = idx < count;

  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = ms_counter;
    // first division starts while the entry is being read
    dreq.divisor = (state == S_TRD) ? pers[idx[IW-1:0]] : rd_per;
    if (state == S_TRD && idx < count && pers[idx[IW-1:0]] != '0) dreq.start = 1'b1;
    if (state == S_DIV0 && drsp.done) begin
      dreq.start = 1'b1;
      dreq.dividend = next_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ms_counter <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_EMIT && state != S_DONE) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          mode <= s_tdata[2:0];
          tid <= s_tdata[10:3];
          per_in <= s_tdata[26:11];
          next_cnt <= ms_counter + s_tdata[25:11];
          idx <= '0;
          err <= 1'b0; busy_f <= 1'b0; idle_f <= 1'b0;
          state <= (s_tdata[2:0] == MODE_TICK) ? S_TRD : S_FIND;
        end
        S_FIND: begin
          // linear search, one entry per cycle
          if (mode == MODE_QUICK || idx >= count || ids[idx[IW-1:0]] == tid)
            state <= S_DECIDE;
          else idx <= idx + CW'(1);
        end
        S_DECIDE: begin
          state <= S_DONE;
          priority if (mode > MODE_STOP) err <= 1'b1;
          else if (mode == MODE_QUICK || (mode == MODE_START && !found)) begin
            if ((mode == MODE_QUICK && (per_in[15] || per_in == '0)) ||
                per_in[15] || count >= CW'(MAX_TASKS)) err <= 1'b1;
            else begin
              ids[count[IW-1:0]] <= tid;
              pers[count[IW-1:0]] <= per_in[CNT_W-1:0];
              count <= count + CW'(1);
              busy_f <= (count == '0);
            end
          end else if (!found) err <= 1'b1;
          else if (per_in[15] || mode == MODE_STOP) state <= S_SHIFT;
          else pers[idx[IW-1:0]] <= per_in[CNT_W-1:0];
        end
        S_SHIFT: begin
          if (idx + CW'(1) < count) begin
            ids[idx[IW-1:0]] <= ids[IW'(idx + CW'(1))];
            pers[idx[IW-1:0]] <= pers[IW'(idx + CW'(1))];
            idx <= idx + CW'(1);
          end else begin
            count <= count - CW'(1);
            idle_f <= (count == CW'(1));
            state <= S_DONE;
          end
        end
        S_TRD: begin
          if (idx >= count) begin
            ms_counter <= next_cnt;
            state <= S_DONE;
          end else begin
            rd_id <= ids[idx[IW-1:0]];
            rd_per <= pers[idx[IW-1:0]];
            if (pers[idx[IW-1:0]] == '0) idx <= idx + CW'(1);
            else state <= S_DIV0;
          end
        end
        S_DIV0: if (drsp.done) begin
          q0 <= drsp.quotient;
          state <= S_DIV1;
        end
        S_DIV1: if (drsp.done) begin
          idx <= idx + CW'(1);
          state <= (q0 != drsp.quotient) ? S_EMIT : S_TRD;
        end
        S_EMIT: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata <= {1'b0, rd_per, rd_id};
          m_tuser <= 4'b0001;
          m_tlast <= 1'b0;
          state <= S_TRD;
        end
        S_DONE: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata <= '0;
          m_tuser <= {idle_f, busy_f, err, 1'b0};
          m_tlast <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TASKS)) else $error("table overflow");
  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tlast) else $error("fired item marked last");
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[2] && m_tuser[3])) else $error("busy and idle together");
endmodule
`default_nettype wire
